// ===== src/sefd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sefd_pkg
// Shared constants and types for the marker framed byte stream decoder.
// ----------------------------------------------------------------------------
package sefd_pkg;

    localparam int MAX_PAYLOAD_BYTES = 1024;
    localparam int LEFT_W            = $clog2(MAX_PAYLOAD_BYTES + 1);

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 11;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 8;

    // result word: payload_byte, frame_type, payload_length, frame_checksum, status
    localparam int RES_BITS = BYTE_W + BYTE_W + LEN_W + BYTE_W + STATUS_W;
    localparam int RES_W    = ((RES_BITS + 7) / 8) * 8;

    typedef enum logic [STATUS_W-1:0] {
        ST_GOOD      = 3'd0,
        ST_BAD_START = 3'd1,
        ST_TOO_LONG  = 3'd2,
        ST_TRUNCATED = 3'd3,
        ST_BAD_END   = 3'd4,
        ST_MISMATCH  = 3'd5
    } status_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_MARKER = 8'd0,
        REG_END_MARKER   = 8'd1
    } cfg_reg_t;

    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'd2;
    localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'd3;

endpackage

`default_nettype wire

// ===== src/stx_etx_frame_decoder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stx_etx_frame_decoder_unit
// Decodes start/length/type/payload/XOR/end frames from a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one received byte per request; tuser flags the first byte
//   of a receive buffer, tlast the last one. m_axis returns payload bytes
//   (tuser = 0) as they arrive and one status request per frame (tuser = 1).
//   Downstream discards payload bytes of a frame whose status is not good.
//   cfg writes the start marker (index 0) and end marker (index 1); it is
//   always ready, to be written only while the decoder is idle (not enforced).
// Timing:
//   One byte per cycle while s_axis_tready is high. Parse state and result
//   register update on the same edge that takes the byte, so a result shows
//   on m_axis in the following cycle. The single output register sets the rate:
//   s_axis_tready stays high while that register is empty or being drained.
// Reset:
//   The parser goes idle awaiting a buffer start, markers return to 2 and 3,
//   and m_axis_tvalid drops. When the receiver stalls, the pending result
//   holds and s_axis_tready falls until it is taken.
// ----------------------------------------------------------------------------
module stx_etx_frame_decoder_unit
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // configuration write channel
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [sefd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sefd_pkg::BYTE_W-1:0]  cfg_data,
    // receive byte stream
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [7:0]                   s_axis_tdata,  // [7:0] rx_byte
    input  wire logic                         s_axis_tuser,  // [0] buffer_start
    input  wire logic                         s_axis_tlast,  // buffer_end
    // decoded output stream
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // [7:0] payload_byte, [15:8] frame_type, [26:16] payload_length,
    // [34:27] frame_checksum, [37:35] status, [39:38] zero
    output logic [sefd_pkg::RES_W-1:0]        m_axis_tdata,
    output logic                              m_axis_tuser   // [0] item_kind
);
    import sefd_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_TYPE,
        PH_PAYLOAD,
        PH_CHECK,
        PH_END_OK,
        PH_END_BAD
    } phase_t;

    localparam logic [15:0]       LEN_LIMIT = 16'(MAX_PAYLOAD_BYTES);
    localparam logic [LEFT_W-1:0] LEFT_ONE  = LEFT_W'(1);

    logic [BYTE_W-1:0] start_marker_reg;
    logic [BYTE_W-1:0] end_marker_reg;

    phase_t            phase_reg, phase_next;
    logic [15:0]       length_word_reg, length_word_next;
    logic [LEFT_W-1:0] bytes_left_reg, bytes_left_next;
    logic [BYTE_W-1:0] running_xor_reg, running_xor_next;
    logic [BYTE_W-1:0] type_byte_reg, type_byte_next;

    logic              out_valid_reg, out_valid_next;
    kind_t             out_kind_reg, out_kind_next;
    logic [BYTE_W-1:0] out_payload_reg, out_payload_next;
    logic [BYTE_W-1:0] out_type_reg, out_type_next;
    logic [LEN_W-1:0]  out_length_reg, out_length_next;
    logic [BYTE_W-1:0] out_check_reg, out_check_next;
    status_t           out_status_reg, out_status_next;

    logic              in_accept;
    logic              cfg_accept;
    logic [BYTE_W-1:0] rx_byte;
    logic              buf_start;
    logic              buf_end;
    logic [15:0]       length_full;
    logic [BYTE_W-1:0] xor_with_byte;

    assign cfg_ready     = 1'b1;
    assign cfg_accept    = cfg_valid && cfg_ready;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign rx_byte       = s_axis_tdata;
    assign buf_start     = s_axis_tuser;
    assign buf_end       = s_axis_tlast;
    assign length_full   = length_word_reg | {8'd0, rx_byte};
    assign xor_with_byte = running_xor_reg ^ rx_byte;

    always_comb
    begin
        phase_next       = phase_reg;
        length_word_next = length_word_reg;
        bytes_left_next  = bytes_left_reg;
        running_xor_next = running_xor_reg;
        type_byte_next   = type_byte_reg;

        out_valid_next   = 1'b0;
        out_kind_next    = KIND_STATUS;
        out_payload_next = '0;
        out_type_next    = type_byte_reg;
        out_length_next  = '0;
        out_check_next   = running_xor_reg;
        out_status_next  = ST_TRUNCATED;

        if (buf_start)
        begin
            length_word_next = '0;
            bytes_left_next  = '0;
            running_xor_next = '0;
            type_byte_next   = '0;
            // abandoned frame reports truncated with its own type and checksum
            out_valid_next   = (phase_reg != PH_IDLE);
            if (rx_byte != start_marker_reg || buf_end)
            begin
                phase_next     = PH_IDLE;
                out_valid_next = 1'b1;
                if (phase_reg == PH_IDLE)
                begin
                    out_type_next   = '0;
                    out_check_next  = '0;
                    out_status_next = (rx_byte != start_marker_reg) ? ST_BAD_START
                                                                    : ST_TRUNCATED;
                end
            end
            else
            begin
                phase_next = PH_LEN_HI;
            end
        end
        else
        begin
            case (phase_reg)
                PH_LEN_HI:
                begin
                    length_word_next = {rx_byte, 8'd0};
                    if (buf_end)
                    begin
                        phase_next     = PH_IDLE;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_LEN_LO;
                    end
                end
                PH_LEN_LO:
                begin
                    length_word_next = length_full;
                    if (length_full > LEN_LIMIT)
                    begin
                        phase_next      = PH_IDLE;
                        out_valid_next  = 1'b1;
                        out_status_next = ST_TOO_LONG;
                    end
                    else if (buf_end)
                    begin
                        phase_next     = PH_IDLE;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        bytes_left_next = length_full[LEFT_W-1:0];
                        phase_next      = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    type_byte_next = rx_byte;
                    out_type_next  = rx_byte;
                    if (buf_end)
                    begin
                        phase_next     = PH_IDLE;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = (bytes_left_reg != '0) ? PH_PAYLOAD : PH_CHECK;
                    end
                end
                PH_PAYLOAD:
                begin
                    running_xor_next = xor_with_byte;
                    if (bytes_left_reg != '0)
                    begin
                        bytes_left_next = bytes_left_reg - LEFT_ONE;
                    end
                    out_valid_next = 1'b1;
                    if (buf_end)
                    begin
                        phase_next     = PH_IDLE;
                        out_check_next = xor_with_byte;
                    end
                    else
                    begin
                        if (bytes_left_reg <= LEFT_ONE)
                        begin
                            phase_next = PH_CHECK;
                        end
                        out_kind_next    = KIND_PAYLOAD;
                        out_payload_next = rx_byte;
                        out_type_next    = '0;
                        out_check_next   = '0;
                        out_status_next  = ST_GOOD;
                    end
                end
                PH_CHECK:
                begin
                    if (buf_end)
                    begin
                        phase_next     = PH_IDLE;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = (rx_byte == running_xor_reg) ? PH_END_OK : PH_END_BAD;
                    end
                end
                PH_END_OK, PH_END_BAD:
                begin
                    phase_next     = PH_IDLE;
                    out_valid_next = 1'b1;
                    if (rx_byte != end_marker_reg)
                    begin
                        out_status_next = ST_BAD_END;
                    end
                    else if (phase_reg == PH_END_BAD)
                    begin
                        out_status_next = ST_MISMATCH;
                    end
                    else
                    begin
                        out_status_next = ST_GOOD;
                        out_length_next = length_word_reg[LEN_W-1:0];
                    end
                end
                default:
                begin
                    // idle without a buffer start: drop the byte
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= START_MARKER_RST;
            end_marker_reg   <= END_MARKER_RST;
        end
        else if (cfg_accept)
        begin
            if (cfg_index == REG_START_MARKER)
            begin
                start_marker_reg <= cfg_data;
            end
            else if (cfg_index == REG_END_MARKER)
            begin
                end_marker_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            length_word_reg <= '0;
            bytes_left_reg  <= '0;
            running_xor_reg <= '0;
            type_byte_reg   <= '0;
            out_valid_reg   <= 1'b0;
            out_kind_reg    <= KIND_PAYLOAD;
            out_payload_reg <= '0;
            out_type_reg    <= '0;
            out_length_reg  <= '0;
            out_check_reg   <= '0;
            out_status_reg  <= ST_GOOD;
        end
        else if (in_accept)
        begin
            phase_reg       <= phase_next;
            length_word_reg <= length_word_next;
            bytes_left_reg  <= bytes_left_next;
            running_xor_reg <= running_xor_next;
            type_byte_reg   <= type_byte_next;
            out_valid_reg   <= out_valid_next;
            if (out_valid_next)
            begin
                out_kind_reg    <= out_kind_next;
                out_payload_reg <= out_payload_next;
                out_type_reg    <= out_type_next;
                out_length_reg  <= out_length_next;
                out_check_reg   <= out_check_next;
                out_status_reg  <= out_status_next;
            end
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = RES_W'({out_status_reg, out_check_reg, out_length_reg,
                                   out_type_reg, out_payload_reg});

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_payload_has_left: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> bytes_left_reg != '0)
        else $error("payload phase with no bytes left");

    a_good_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg == KIND_STATUS && out_status_reg == ST_GOOD
        |-> 16'(out_length_reg) <= LEN_LIMIT)
        else $error("good status with length above limit");

    a_bad_has_no_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg == KIND_STATUS && out_status_reg != ST_GOOD
        |-> out_length_reg == '0)
        else $error("failed frame reports a length");

    a_payload_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg == KIND_PAYLOAD
        |-> out_status_reg == ST_GOOD && out_type_reg == '0 && out_check_reg == '0)
        else $error("payload request carries status fields");

    a_idle_after_status: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && out_valid_next && out_kind_next == KIND_STATUS && !buf_start
        |=> phase_reg == PH_IDLE)
        else $error("parser not idle after frame status");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the STX/ETX frame decoder unit.
// Streams receive buffers (good, corrupted, cut short, abandoned, oversize,
// noise) under several marker settings, predicts every payload and status
// request in the bench, and compares the output stream in order.
// ----------------------------------------------------------------------------
module tb;

    import sefd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef enum logic [2:0] {
        P_IDLE, P_LEN_HI, P_LEN_LO, P_TYPE, P_DATA, P_CSUM, P_END_OK, P_END_BAD
    } parse_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
    } rx_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic [7:0]  ftype;
        logic [10:0] plen;
        logic [7:0]  csum;
        status_t     status;
    } frame_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]    cfg_data = '0;

    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;   // [7:0] rx_byte
    logic       s_axis_tuser = 1'b0; // [0] buffer_start
    logic       s_axis_tlast = 1'b0; // buffer_end

    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    // [7:0] payload_byte, [15:8] frame_type, [26:16] payload_length,
    // [34:27] frame_checksum, [37:35] status, [39:38] zero
    logic [RES_W-1:0] m_axis_tdata;
    logic             m_axis_tuser;  // [0] item_kind

    // decoder state as the bench sees it
    parse_phase_t ph = P_IDLE;
    logic [15:0]  len_word = '0;
    logic [10:0]  pay_left = '0;
    logic [7:0]   cur_xor = '0;
    logic [7:0]   cur_type = '0;
    logic [7:0]   start_mk = START_MARKER_RST;
    logic [7:0]   end_mk = END_MARKER_RST;

    rx_item_t      feed_q[$];
    frame_result_t expect_q[$];
    rx_item_t      in_flight;
    int            bytes_taken = 0;
    int            err_count = 0;
    int            cycles = 0;
    int            hold_left = 0;
    logic          hold_done = 1'b0;
    logic          gap_free;

    assign gap_free = (bytes_taken >= 600) && (bytes_taken < 850);

    stx_etx_frame_decoder_unit uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 clk = ~clk;

    function automatic frame_result_t status_item(input logic [7:0] t, input logic [7:0] x,
                                                  input logic [10:0] n, input status_t st);
        frame_result_t r;
        r = '0;
        r.kind   = KIND_STATUS;
        r.ftype  = t;
        r.plen   = n;
        r.csum   = x;
        r.status = st;
        return r;
    endfunction

    function automatic string fmt_result(input frame_result_t r);
        return $sformatf("kind=%0d byte=%02h type=%02h len=%0d csum=%02h status=%0d",
                         r.kind, r.data, r.ftype, r.plen, r.csum, r.status);
    endfunction

    task automatic note_error(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("%0t ns: %s", $time, msg);
    endtask

    // Advance the frame parser by one accepted byte; queue what it emits.
    task automatic decode_byte(input rx_item_t it);
        frame_result_t r;
        logic          emit;
        logic          fail;
        status_t       fail_code;
        logic          end_ok;
        r = '0;
        emit = 1'b0;
        fail = 1'b0;
        fail_code = ST_TRUNCATED;
        if (it.first)
        begin
            // an open frame is closed as truncated; a bad new buffer is then dropped
            if (ph != P_IDLE)
            begin
                emit = 1'b1;
                r = status_item(cur_type, cur_xor, '0, ST_TRUNCATED);
            end
            else if (it.data != start_mk || it.last)
            begin
                emit = 1'b1;
                r = status_item('0, '0, '0,
                                (it.data != start_mk) ? ST_BAD_START : ST_TRUNCATED);
            end
            len_word = '0;
            pay_left = '0;
            cur_xor  = '0;
            cur_type = '0;
            ph = (it.data == start_mk && !it.last) ? P_LEN_HI : P_IDLE;
        end
        else
        begin
            case (ph)
                P_LEN_HI:
                begin
                    len_word = {it.data, 8'h00};
                    if (it.last)
                        fail = 1'b1;
                    else
                        ph = P_LEN_LO;
                end
                P_LEN_LO:
                begin
                    len_word[7:0] = it.data;
                    if (len_word > MAX_PAYLOAD_BYTES)
                    begin
                        fail = 1'b1;
                        fail_code = ST_TOO_LONG;
                    end
                    else if (it.last)
                        fail = 1'b1;
                    else
                    begin
                        pay_left = len_word[10:0];
                        ph = P_TYPE;
                    end
                end
                P_TYPE:
                begin
                    cur_type = it.data;
                    if (it.last)
                        fail = 1'b1;
                    else
                        ph = (pay_left != 0) ? P_DATA : P_CSUM;
                end
                P_DATA:
                begin
                    cur_xor = cur_xor ^ it.data;
                    if (pay_left != 0)
                        pay_left = pay_left - 11'd1;
                    if (it.last)
                        fail = 1'b1;
                    else
                    begin
                        if (pay_left == 0)
                            ph = P_CSUM;
                        emit = 1'b1;
                        r.kind = KIND_PAYLOAD;
                        r.data = it.data;
                    end
                end
                P_CSUM:
                begin
                    if (it.last)
                        fail = 1'b1;
                    else
                        ph = (it.data == cur_xor) ? P_END_OK : P_END_BAD;
                end
                P_END_OK, P_END_BAD:
                begin
                    // bad end wins over a checksum mismatch
                    end_ok = (ph == P_END_OK);
                    ph = P_IDLE;
                    emit = 1'b1;
                    if (it.data != end_mk)
                        r = status_item(cur_type, cur_xor, '0, ST_BAD_END);
                    else if (!end_ok)
                        r = status_item(cur_type, cur_xor, '0, ST_MISMATCH);
                    else
                        r = status_item(cur_type, cur_xor, len_word[10:0], ST_GOOD);
                end
                default: ;
            endcase
        end
        if (fail)
        begin
            ph = P_IDLE;
            emit = 1'b1;
            r = status_item(cur_type, cur_xor, '0, fail_code);
        end
        if (emit)
            expect_q.push_back(r);
    endtask

    task automatic push_byte(input logic [7:0] d, input logic f, input logic l);
        rx_item_t it;
        it.data  = d;
        it.first = f;
        it.last  = l;
        feed_q.push_back(it);
    endtask

    // Queue one receive buffer; mode selects the damage, below 0 picks at random.
    task automatic add_buffer(input int mode, input int force_len, output int n);
        logic [7:0]  fb[$];
        logic [15:0] lw;
        logic [7:0]  sum;
        logic [7:0]  b;
        int          roll;
        int          len;
        int          i;
        int          cut;
        logic        close;
        roll = (mode < 0) ? $urandom_range(0, 99) : mode;
        close = 1'b1;
        if (mode < 0 && $urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 2))
                push_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
        if (force_len >= 0)
            len = force_len;
        else if ($urandom_range(0, 29) == 0)
            len = $urandom_range(17, 300);
        else
            len = $urandom_range(0, 12);
        lw = 16'(len);
        if (roll >= 96)
        begin
            case ($urandom_range(0, 3))
                0:       lw = 16'hFFFF;
                1:       lw = 16'(MAX_PAYLOAD_BYTES + 1);
                default: lw = 16'($urandom_range(MAX_PAYLOAD_BYTES + 1, 65535));
            endcase
        end
        fb.push_back(start_mk);
        fb.push_back(lw[15:8]);
        fb.push_back(lw[7:0]);
        fb.push_back(8'($urandom_range(0, 255)));
        sum = 8'h00;
        if (roll >= 96)
        begin
            repeat ($urandom_range(0, 3))
                fb.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            for (i = 0; i < len; i++)
            begin
                b = 8'($urandom_range(0, 255));
                sum = sum ^ b;
                fb.push_back(b);
            end
            fb.push_back(sum);
            fb.push_back(end_mk);
            if (roll >= 60 && roll < 70)
                fb[fb.size() - 2] = fb[fb.size() - 2] ^ 8'($urandom_range(1, 255));
            else if (roll >= 70 && roll < 78)
            begin
                do b = 8'($urandom_range(0, 255)); while (b == end_mk);
                fb[fb.size() - 1] = b;
                if ($urandom_range(0, 1) == 1)
                    fb[fb.size() - 2] = fb[fb.size() - 2] ^ 8'($urandom_range(1, 255));
            end
            else if (roll >= 78 && roll < 91)
            begin
                // cut short before the end marker; the upper part leaves the buffer open
                cut = $urandom_range(0, fb.size() - 2);
                while (fb.size() > cut + 1)
                    void'(fb.pop_back());
                close = (roll < 86);
            end
            else if (roll >= 91)
            begin
                do b = 8'($urandom_range(0, 255)); while (b == start_mk);
                fb[0] = b;
                if ($urandom_range(0, 2) == 0)
                    while (fb.size() > 1)
                        void'(fb.pop_back());
            end
            if (roll < 78 && $urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3))
                    fb.push_back(8'($urandom_range(0, 255)));
        end
        for (i = 0; i < fb.size(); i++)
            push_byte(fb[i], i == 0, close && (i == fb.size() - 1));
        n = fb.size();
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [7:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_START_MARKER)
            start_mk = val;
        else
            end_mk = val;
        cfg_valid <= 1'b0;
    endtask

    // Hold until every request is in and out, then let the pipeline settle.
    task automatic drain();
        while (feed_q.size() != 0 || s_axis_tvalid || expect_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_byte(in_flight);
                bytes_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (feed_q.size() != 0 && (gap_free || $urandom_range(0, 99) >= 36))
                begin
                    in_flight = feed_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= in_flight.data;
                    s_axis_tuser  <= in_flight.first;
                    s_axis_tlast  <= in_flight.last;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        frame_result_t got;
        frame_result_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.kind   = kind_t'(m_axis_tuser);
                got.data   = m_axis_tdata[7:0];
                got.ftype  = m_axis_tdata[15:8];
                got.plen   = m_axis_tdata[26:16];
                got.csum   = m_axis_tdata[34:27];
                got.status = status_t'(m_axis_tdata[37:35]);
                if (expect_q.size() == 0)
                    note_error({"unexpected request: ", fmt_result(got)});
                else
                begin
                    want = expect_q.pop_front();
                    if (got.kind !== want.kind || got.data !== want.data
                        || got.ftype !== want.ftype || got.plen !== want.plen
                        || got.csum !== want.csum || got.status !== want.status)
                        note_error({"expected ", fmt_result(want), "\n        got      ",
                                    fmt_result(got)});
                end
            end
            // one long hold-off to back the decoder up into its input
            if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!hold_done && bytes_taken >= 300)
            begin
                hold_done = 1'b1;
                hold_left = 150;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= gap_free || ($urandom_range(0, 99) >= 36);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] sm;
        logic [7:0] em;
        int         p;
        int         n;
        int         taken;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: noise, bad start, one-byte buffer, good frame with trailing
        // junk, oversize length ending the buffer, abandoned frame, bad end
        push_byte(8'h55, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b1, 1'b0);
        push_byte(START_MARKER_RST, 1'b1, 1'b1);
        push_byte(START_MARKER_RST, 1'b1, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h02, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(END_MARKER_RST, 1'b0, 1'b0);
        push_byte(8'hAA, 1'b0, 1'b1);
        push_byte(START_MARKER_RST, 1'b1, 1'b0);
        push_byte(8'h04, 1'b0, 1'b0);
        push_byte(8'h01, 1'b0, 1'b1);
        push_byte(START_MARKER_RST, 1'b1, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(START_MARKER_RST, 1'b1, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h7E, 1'b0, 1'b0);
        push_byte(8'h55, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b1);
        drain();

        for (p = 0; p < 5; p++)
        begin
            case (p)
                0:       begin sm = 8'h00; em = 8'hFF; end
                1:       begin sm = 8'hFF; em = 8'h00; end
                2:       begin sm = 8'h7E; em = 8'h7E; end
                3:       begin sm = 8'($urandom_range(0, 255)); em = 8'($urandom_range(0, 255)); end
                default: begin sm = START_MARKER_RST; em = END_MARKER_RST; end
            endcase
            write_reg(REG_START_MARKER, sm);
            write_reg(REG_END_MARKER, em);
            taken = 0;
            while (taken < 180)
            begin
                add_buffer(-1, -1, n);
                taken += n;
            end
            // close on a good frame so the parser is idle for the next write
            add_buffer(0, -1, n);
            drain();
        end

        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/sefd_pkg.sv
src/stx_etx_frame_decoder_unit.sv
tb/tb.sv
